/* hdl/stfm_pkg.sv */
// ----------------------------------------------------------------------------
// stfm_pkg
// Shared constants, codes and control types of the sample table fuzzy match
// unit.
// ----------------------------------------------------------------------------
package stfm_pkg;

  localparam int MAX_ENTRIES_DEF = 256;
  localparam int OFFSET_BITS_DEF = 24;

  localparam int OP_W     = 2;
  localparam int DATA_W   = 24;
  localparam int LEN_W    = 24;
  localparam int RATE_W   = 16;
  localparam int ID_W     = 8;
  localparam int STATUS_W = 3;

  localparam int DEFAULT_RATE   = 4000;
  localparam int FRAMES_PER_SEC = 60;

  // frame = rate / 60 as (rate * RECIP) >> RECIP_SHIFT, exact for 16-bit rates
  localparam int RECIP_SHIFT = 22;
  localparam int RECIP       = (1 << RECIP_SHIFT) / FRAMES_PER_SEC + 1;
  localparam int PROD_W      = RATE_W + 17;
  localparam int FRAME_W     = PROD_W - RECIP_SHIFT;
  localparam logic [FRAME_W-1:0] DEFAULT_FRAME = FRAME_W'(DEFAULT_RATE / FRAMES_PER_SEC);

  localparam logic [OP_W-1:0] OP_ADD_SAMPLE = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD_BLOCK  = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND_OFF   = 2'd2;
  localparam logic [OP_W-1:0] OP_FIND_ID    = 2'd3;

  localparam logic [STATUS_W-1:0] ST_ADDED      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_CONFIRMED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_LENGTHENED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MATCHED    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd5;

  typedef struct packed {
    logic valid;
    logic found;
  } tok_ctl_t;

  typedef struct packed {
    logic en;
    logic off;
    logic len;
    logic rate;
  } wr_ctl_t;

endpackage

/* hdl/sample_table_fuzzy_match_unit.sv */
// ----------------------------------------------------------------------------
// sample_table_fuzzy_match_unit
// Sample table with fuzzy offset match, built as a chain of entry cells.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. Entries live in a chain of MAX_ENTRIES
// cells; a search token enters at the top cell and walks one cell per cycle
// down to entry 0, so every add_sample, find_by_offset and find_by_id waits
// for the token to pass the whole chain before its result is formed, while
// add_block goes straight to the result stage. One item is worked on at a time;
// a finished result is held in the output register, and the next input beat
// is taken while it waits. Table contents are not cleared by reset; only
// entries below the entry count are ever looked at.
module sample_table_fuzzy_match_unit #(
  parameter int MAX_ENTRIES = stfm_pkg::MAX_ENTRIES_DEF,
  parameter int OFFSET_BITS = stfm_pkg::OFFSET_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [stfm_pkg::OP_W-1:0]       in_operation,
  input  logic [stfm_pkg::DATA_W-1:0]     in_data_offset,
  input  logic [stfm_pkg::LEN_W-1:0]      in_sample_len,
  input  logic [stfm_pkg::RATE_W-1:0]     in_rate,
  input  logic [stfm_pkg::ID_W-1:0]       in_sample_id,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [stfm_pkg::STATUS_W-1:0]   out_status,
  output logic [stfm_pkg::ID_W-1:0]       out_entry_id,
  output logic [stfm_pkg::DATA_W-1:0]     out_entry_offset,
  output logic [stfm_pkg::LEN_W-1:0]      out_entry_length,
  output logic [stfm_pkg::RATE_W-1:0]     out_entry_rate
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int QID_W = IDX_W + stfm_pkg::ID_W;
  localparam int SUM_W = ((OFFSET_BITS > stfm_pkg::LEN_W) ? OFFSET_BITS : stfm_pkg::LEN_W) + 1;
  localparam int OFX_W = OFFSET_BITS + stfm_pkg::DATA_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       start_r;

  logic [stfm_pkg::OP_W-1:0]    op_r;
  logic [OFFSET_BITS-1:0]       q_off_r;
  logic [stfm_pkg::LEN_W-1:0]   len_r;
  logic [stfm_pkg::RATE_W-1:0]  rate_r;
  logic [stfm_pkg::ID_W-1:0]    id_r;
  logic [stfm_pkg::FRAME_W-1:0] frame_r;

  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       count_nxt;
  logic [OFFSET_BITS-1:0] bank_r;
  logic [OFFSET_BITS-1:0] bank_nxt;

  logic                        hit_found_r;
  logic [IDX_W-1:0]            hit_idx_r;
  logic [OFFSET_BITS-1:0]      hit_off_r;
  logic [stfm_pkg::LEN_W-1:0]  hit_len_r;
  logic [stfm_pkg::RATE_W-1:0] hit_rate_r;

  logic                          out_valid_r;
  logic [stfm_pkg::STATUS_W-1:0] out_status_r;
  logic [stfm_pkg::ID_W-1:0]     out_id_r;
  logic [stfm_pkg::DATA_W-1:0]   out_off_r;
  logic [stfm_pkg::LEN_W-1:0]    out_len_r;
  logic [stfm_pkg::RATE_W-1:0]   out_rate_r;

  logic                        accept;
  logic                        fin_go;
  logic [stfm_pkg::PROD_W-1:0] prod;
  logic [stfm_pkg::FRAME_W-1:0] frame_in;
  logic [OFX_W-1:0]            off_in_ext;
  logic [QID_W-1:0]            q_id;
  logic                        full;
  logic [SUM_W-1:0]            bank_sum;

  stfm_pkg::wr_ctl_t           wr_ctl;
  logic [IDX_W-1:0]            wr_idx;
  logic [OFFSET_BITS-1:0]      wr_off;
  logic [stfm_pkg::LEN_W-1:0]  wr_len;
  logic [stfm_pkg::RATE_W-1:0] wr_rate;
  logic [stfm_pkg::FRAME_W-1:0] wr_frame;

  logic [stfm_pkg::STATUS_W-1:0] res_status;
  logic                          res_valid;
  logic [IDX_W-1:0]              res_idx;
  logic [OFFSET_BITS-1:0]        res_off;
  logic [stfm_pkg::LEN_W-1:0]    res_len;
  logic [stfm_pkg::RATE_W-1:0]   res_rate;
  logic [QID_W-1:0]              res_id_ext;
  logic [OFX_W-1:0]              res_off_ext;

  stfm_pkg::tok_ctl_t          ch_ctl  [0:MAX_ENTRIES];
  logic [IDX_W-1:0]            ch_idx  [0:MAX_ENTRIES];
  logic [OFFSET_BITS-1:0]      ch_off  [0:MAX_ENTRIES];
  logic [stfm_pkg::LEN_W-1:0]  ch_len  [0:MAX_ENTRIES];
  logic [stfm_pkg::RATE_W-1:0] ch_rate [0:MAX_ENTRIES];

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign fin_go   = (state_r == S_FIN) && (!out_valid_r || out_ready);

  // frame length of the incoming rate
  assign prod       = stfm_pkg::PROD_W'(in_rate) * stfm_pkg::PROD_W'(stfm_pkg::RECIP);
  assign frame_in   = (in_rate == '0) ? stfm_pkg::DEFAULT_FRAME
                                      : prod[stfm_pkg::PROD_W-1:stfm_pkg::RECIP_SHIFT];
  assign off_in_ext = {{OFFSET_BITS{1'b0}}, in_data_offset};
  assign q_id       = {{IDX_W{1'b0}}, id_r};

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_operation;
      q_off_r <= off_in_ext[OFFSET_BITS-1:0];
      len_r   <= in_sample_len;
      rate_r  <= in_rate;
      id_r    <= in_sample_id;
      frame_r <= frame_in;
    end
  end

  // search chain, top cell first, entry 0 last
  assign ch_ctl[MAX_ENTRIES]  = '{valid: start_r, found: 1'b0};
  assign ch_idx[MAX_ENTRIES]  = '0;
  assign ch_off[MAX_ENTRIES]  = '0;
  assign ch_len[MAX_ENTRIES]  = '0;
  assign ch_rate[MAX_ENTRIES] = '0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    stfm_cell #(
      .IDX   (i),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W),
      .OFF_W (OFFSET_BITS),
      .QID_W (QID_W)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .entry_count (count_r),
      .by_id       (op_r == stfm_pkg::OP_FIND_ID),
      .q_off       (q_off_r),
      .q_id        (q_id),
      .wr_ctl      (wr_ctl),
      .wr_idx      (wr_idx),
      .wr_off      (wr_off),
      .wr_len      (wr_len),
      .wr_rate     (wr_rate),
      .wr_frame    (wr_frame),
      .tok_in      (ch_ctl[i+1]),
      .tin_idx     (ch_idx[i+1]),
      .tin_off     (ch_off[i+1]),
      .tin_len     (ch_len[i+1]),
      .tin_rate    (ch_rate[i+1]),
      .tok_out     (ch_ctl[i]),
      .tout_idx    (ch_idx[i]),
      .tout_off    (ch_off[i]),
      .tout_len    (ch_len[i]),
      .tout_rate   (ch_rate[i])
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_operation == stfm_pkg::OP_ADD_BLOCK) ? S_FIN : S_SCAN;
        end
      end
      S_SCAN: begin
        if (ch_ctl[0].valid) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= accept && (in_operation != stfm_pkg::OP_ADD_BLOCK);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_SCAN && ch_ctl[0].valid) begin
      hit_found_r <= ch_ctl[0].found;
      hit_idx_r   <= ch_idx[0];
      hit_off_r   <= ch_off[0];
      hit_len_r   <= ch_len[0];
      hit_rate_r  <= ch_rate[0];
    end
  end

  // outcome of the item
  assign full     = count_r >= CNT_W'(MAX_ENTRIES);
  assign bank_sum = SUM_W'(bank_r) + SUM_W'(len_r);

  always_comb begin
    wr_ctl     = '0;
    wr_idx     = count_r[IDX_W-1:0];
    wr_off     = q_off_r;
    wr_len     = len_r;
    wr_rate    = rate_r;
    wr_frame   = frame_r;
    count_nxt  = count_r;
    bank_nxt   = bank_r;
    res_status = stfm_pkg::ST_MATCHED;
    res_valid  = 1'b1;
    res_idx    = hit_idx_r;
    res_off    = hit_off_r;
    res_len    = hit_len_r;
    res_rate   = hit_rate_r;
    unique case (op_r)
      stfm_pkg::OP_ADD_SAMPLE: begin
        priority if (!hit_found_r && full) begin
          res_status = stfm_pkg::ST_FULL;
          res_valid  = 1'b0;
        end else if (!hit_found_r) begin
          wr_ctl     = '{en: 1'b1, off: 1'b1, len: 1'b1, rate: 1'b1};
          count_nxt  = count_r + CNT_W'(1);
          res_status = stfm_pkg::ST_ADDED;
          res_idx    = count_r[IDX_W-1:0];
          res_off    = q_off_r;
          res_len    = len_r;
          res_rate   = rate_r;
        end else if (hit_rate_r == '0) begin
          wr_ctl     = '{en: 1'b1, off: 1'b0, len: 1'b1, rate: 1'b1};
          wr_idx     = hit_idx_r;
          res_status = stfm_pkg::ST_CONFIRMED;
          res_len    = len_r;
          res_rate   = rate_r;
        end else if (hit_len_r < len_r) begin
          wr_ctl     = '{en: 1'b1, off: 1'b0, len: 1'b1, rate: 1'b0};
          wr_idx     = hit_idx_r;
          res_status = stfm_pkg::ST_LENGTHENED;
          res_len    = len_r;
        end else begin
          res_status = stfm_pkg::ST_MATCHED;
        end
      end
      stfm_pkg::OP_ADD_BLOCK: begin
        if (full) begin
          res_status = stfm_pkg::ST_FULL;
          res_valid  = 1'b0;
        end else begin
          wr_ctl     = '{en: 1'b1, off: 1'b1, len: 1'b1, rate: 1'b1};
          wr_off     = bank_r;
          wr_rate    = '0;
          wr_frame   = stfm_pkg::DEFAULT_FRAME;
          count_nxt  = count_r + CNT_W'(1);
          // saturate at the top offset
          bank_nxt   = (bank_sum[SUM_W-1:OFFSET_BITS] != '0) ? '1
                                                            : bank_sum[OFFSET_BITS-1:0];
          res_status = stfm_pkg::ST_ADDED;
          res_idx    = count_r[IDX_W-1:0];
          res_off    = bank_r;
          res_len    = len_r;
          res_rate   = '0;
        end
      end
      stfm_pkg::OP_FIND_OFF, stfm_pkg::OP_FIND_ID: begin
        if (!hit_found_r) begin
          res_status = stfm_pkg::ST_NOT_FOUND;
          res_valid  = 1'b0;
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
    if (!fin_go) begin
      wr_ctl = '0;
    end
  end

  assign res_id_ext  = {{stfm_pkg::ID_W{1'b0}}, res_idx};
  assign res_off_ext = {{stfm_pkg::DATA_W{1'b0}}, res_off};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      bank_r  <= '0;
    end else if (fin_go) begin
      count_r <= count_nxt;
      bank_r  <= bank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_status_r <= res_status;
      out_id_r     <= res_valid ? res_id_ext[stfm_pkg::ID_W-1:0] : '0;
      out_off_r    <= res_valid ? res_off_ext[stfm_pkg::DATA_W-1:0] : '0;
      out_len_r    <= res_valid ? res_len : '0;
      out_rate_r   <= res_valid ? res_rate : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_entry_id     = out_id_r;
  assign out_entry_offset = out_off_r;
  assign out_entry_length = out_len_r;
  assign out_entry_rate   = out_rate_r;

endmodule

/* hdl/stfm_cell.sv */
// ----------------------------------------------------------------------------
// stfm_cell
// One table entry with its own compare; the search token passes through it
// towards entry 0 and picks up the entry on a match.
// ----------------------------------------------------------------------------
module stfm_cell #(
  parameter int IDX   = 0,
  parameter int IDX_W = 8,
  parameter int CNT_W = 9,
  parameter int OFF_W = 24,
  parameter int QID_W = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [CNT_W-1:0]             entry_count,
  input  logic                         by_id,
  input  logic [OFF_W-1:0]             q_off,
  input  logic [QID_W-1:0]             q_id,
  input  stfm_pkg::wr_ctl_t            wr_ctl,
  input  logic [IDX_W-1:0]             wr_idx,
  input  logic [OFF_W-1:0]             wr_off,
  input  logic [stfm_pkg::LEN_W-1:0]   wr_len,
  input  logic [stfm_pkg::RATE_W-1:0]  wr_rate,
  input  logic [stfm_pkg::FRAME_W-1:0] wr_frame,
  input  stfm_pkg::tok_ctl_t           tok_in,
  input  logic [IDX_W-1:0]             tin_idx,
  input  logic [OFF_W-1:0]             tin_off,
  input  logic [stfm_pkg::LEN_W-1:0]   tin_len,
  input  logic [stfm_pkg::RATE_W-1:0]  tin_rate,
  output stfm_pkg::tok_ctl_t           tok_out,
  output logic [IDX_W-1:0]             tout_idx,
  output logic [OFF_W-1:0]             tout_off,
  output logic [stfm_pkg::LEN_W-1:0]   tout_len,
  output logic [stfm_pkg::RATE_W-1:0]  tout_rate
);

  logic [OFF_W-1:0]             off_r;
  logic [stfm_pkg::LEN_W-1:0]   len_r;
  logic [stfm_pkg::RATE_W-1:0]  rate_r;
  logic [stfm_pkg::FRAME_W-1:0] frame_r;

  stfm_pkg::tok_ctl_t  tok_r;
  logic [IDX_W-1:0]    tidx_r;
  logic [OFF_W-1:0]    toff_r;
  logic [stfm_pkg::LEN_W-1:0]  tlen_r;
  logic [stfm_pkg::RATE_W-1:0] trate_r;

  logic [OFF_W-1:0] off_delta;
  logic             active;
  logic             match_off;
  logic             match_id;
  logic             hit;
  logic             sel;

  assign off_delta = (off_r >= q_off) ? off_r - q_off : q_off - off_r;
  assign match_off = off_delta < OFF_W'(frame_r);
  assign match_id  = q_id == QID_W'(IDX);
  assign active    = CNT_W'(IDX) < entry_count;
  // entry 0 wins over any later match
  assign hit = tok_in.valid && active && (by_id ? match_id : match_off)
               && ((IDX == 0) || !tok_in.found);
  assign sel = wr_ctl.en && (wr_idx == IDX_W'(IDX));

  always_ff @(posedge clk) begin
    if (sel && wr_ctl.off) begin
      off_r <= wr_off;
    end
    if (sel && wr_ctl.len) begin
      len_r <= wr_len;
    end
    if (sel && wr_ctl.rate) begin
      rate_r  <= wr_rate;
      frame_r <= wr_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r.valid <= tok_in.valid;
      tok_r.found <= tok_in.found || hit;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      tidx_r  <= IDX_W'(IDX);
      toff_r  <= off_r;
      tlen_r  <= len_r;
      trate_r <= rate_r;
    end else begin
      tidx_r  <= tin_idx;
      toff_r  <= tin_off;
      tlen_r  <= tin_len;
      trate_r <= tin_rate;
    end
  end

  assign tok_out   = tok_r;
  assign tout_idx  = tidx_r;
  assign tout_off  = toff_r;
  assign tout_len  = tlen_r;
  assign tout_rate = trate_r;

endmodule

/* tb/tb_sample_table_fuzzy_match_unit.sv */
// ----------------------------------------------------------------------------
// tb_sample_table_fuzzy_match_unit
// Self-checking bench for the sample table fuzzy match unit.
// ----------------------------------------------------------------------------
// A short table of directed beats comes first: the empty table, offset
// matches at the frame edge, confirm, lengthen, low rates, bank saturation
// and ids out of range. Random beats follow. Most of them aim near the
// offsets already stored, so that matches happen. The table is then filled
// until adds report it full. Every result is compared field by field with
// its directed row or the table model. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_sample_table_fuzzy_match_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import stfm_pkg::*;

  localparam int TABLE_DEPTH = MAX_ENTRIES_DEF;
  localparam int N_RANDOM    = 830;
  localparam int FILL_AT     = 520;
  localparam int TAIL_CYCLES = 2 * (TABLE_DEPTH + 3);
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam logic [DATA_W-1:0] BANK_TOP = {DATA_W{1'b1}};

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     id;
    logic [DATA_W-1:0]   offset;
    logic [LEN_W-1:0]    length;
    logic [RATE_W-1:0]   rate;
  } entry_result_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] off;
    logic [LEN_W-1:0]  len;
    logic [RATE_W-1:0] rate;
    logic [ID_W-1:0]   id;
    logic              typed;
    entry_result_t     want;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     in_operation = '0;
  logic [DATA_W-1:0]   in_data_offset = '0;
  logic [LEN_W-1:0]    in_sample_len = '0;
  logic [RATE_W-1:0]   in_rate = '0;
  logic [ID_W-1:0]     in_sample_id = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [ID_W-1:0]     out_entry_id;
  logic [DATA_W-1:0]   out_entry_offset;
  logic [LEN_W-1:0]    out_entry_length;
  logic [RATE_W-1:0]   out_entry_rate;

  // bench copy of the table
  logic [DATA_W-1:0] tab_off  [TABLE_DEPTH];
  logic [LEN_W-1:0]  tab_len  [TABLE_DEPTH];
  logic [RATE_W-1:0] tab_rate [TABLE_DEPTH];
  int                tab_count = 0;
  logic [DATA_W-1:0] bank_len = '0;

  entry_result_t pending_results[$];
  stim_row_t     directed_rows[$];

  int  fails = 0;
  int  results_seen = 0;
  int  items_sent = 0;
  int  status_hist[8];
  int  cycles = 0;
  int  ready_hold = 0;
  logic calm = 1'b0;

  sample_table_fuzzy_match_unit #(
    .MAX_ENTRIES(TABLE_DEPTH),
    .OFFSET_BITS(OFFSET_BITS_DEF)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_data_offset   (in_data_offset),
    .in_sample_len    (in_sample_len),
    .in_rate          (in_rate),
    .in_sample_id     (in_sample_id),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_entry_id     (out_entry_id),
    .out_entry_offset (out_entry_offset),
    .out_entry_length (out_entry_length),
    .out_entry_rate   (out_entry_rate)
  );

  always #5 clk = ~clk;

  function automatic int frame_bytes(logic [RATE_W-1:0] r);
    if (r == '0) return DEFAULT_RATE / FRAMES_PER_SEC;
    return int'(r) / FRAMES_PER_SEC;
  endfunction

  // entry 0 first, then newest to oldest
  function automatic int find_near_offset(logic [DATA_W-1:0] off);
    int k, idx, d;
    for (k = 0; k < tab_count; k++) begin
      idx = (k == 0) ? 0 : tab_count - k;
      d = int'(tab_off[idx]) - int'(off);
      if (d < 0) d = -d;
      if (d < frame_bytes(tab_rate[idx])) return idx;
    end
    return -1;
  endfunction

  function automatic entry_result_t entry_view(logic [STATUS_W-1:0] st, int idx);
    entry_result_t r;
    r.status = st;
    r.id     = ID_W'(idx);
    r.offset = tab_off[idx];
    r.length = tab_len[idx];
    r.rate   = tab_rate[idx];
    return r;
  endfunction

  task automatic table_update(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] off,
                              input logic [LEN_W-1:0] len, input logic [RATE_W-1:0] rate,
                              input logic [ID_W-1:0] id, output entry_result_t r);
    int hit;
    logic [DATA_W:0] sum;
    r = '0;
    case (op)
      OP_ADD_SAMPLE: begin
        hit = find_near_offset(off);
        if (hit < 0) begin
          if (tab_count >= TABLE_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            tab_off[tab_count]  = off;
            tab_len[tab_count]  = len;
            tab_rate[tab_count] = rate;
            tab_count++;
            r = entry_view(ST_ADDED, tab_count - 1);
          end
        end else if (tab_rate[hit] == '0) begin
          tab_rate[hit] = rate;
          tab_len[hit]  = len;
          r = entry_view(ST_CONFIRMED, hit);
        end else if (tab_len[hit] < len) begin
          tab_len[hit] = len;
          r = entry_view(ST_LENGTHENED, hit);
        end else begin
          r = entry_view(ST_MATCHED, hit);
        end
      end
      OP_ADD_BLOCK: begin
        if (tab_count >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          tab_off[tab_count]  = bank_len;
          tab_len[tab_count]  = len;
          tab_rate[tab_count] = '0;
          tab_count++;
          sum = {1'b0, bank_len} + {1'b0, len};
          bank_len = sum[DATA_W] ? BANK_TOP : sum[DATA_W-1:0];
          r = entry_view(ST_ADDED, tab_count - 1);
        end
      end
      OP_FIND_OFF: begin
        hit = find_near_offset(off);
        if (hit < 0) r.status = ST_NOT_FOUND;
        else r = entry_view(ST_MATCHED, hit);
      end
      default: begin
        if (int'(id) < tab_count) r = entry_view(ST_MATCHED, int'(id));
        else r.status = ST_NOT_FOUND;
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at result %0d: %s got %0h expected %0h", results_seen, what, got, want);
    fails++;
  endtask

  task automatic check_beat(input entry_result_t got, input entry_result_t want);
    if (got.status !== want.status)
      report_mismatch("status", longint'(got.status), longint'(want.status));
    if (got.id !== want.id)
      report_mismatch("entry_id", longint'(got.id), longint'(want.id));
    if (got.offset !== want.offset)
      report_mismatch("entry_offset", longint'(got.offset), longint'(want.offset));
    if (got.length !== want.length)
      report_mismatch("entry_length", longint'(got.length), longint'(want.length));
    if (got.rate !== want.rate)
      report_mismatch("entry_rate", longint'(got.rate), longint'(want.rate));
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 20);
    return $urandom_range(100, 300);
  endfunction

  // result side: random back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
      ready_hold = 0;
    end else if (ready_hold > 0) begin
      ready_hold--;
    end else if ($urandom_range(0, 99) < 65) begin
      out_ready <= 1'b1;
      ready_hold = $urandom_range(0, 20);
    end else begin
      out_ready <= 1'b0;
      ready_hold = pick_gap();
    end
  end

  always @(posedge clk) begin : result_monitor
    entry_result_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_status, out_entry_id, out_entry_offset, out_entry_length, out_entry_rate};
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with none pending, status", longint'(got.status),
                        longint'(0));
      end else begin
        want = pending_results.pop_front();
        check_beat(got, want);
      end
      status_hist[got.status]++;
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("run stopped by cycle limit after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] off,
                           input logic [LEN_W-1:0] len, input logic [RATE_W-1:0] rate,
                           input logic [ID_W-1:0] id, input logic typed,
                           input entry_result_t want);
    entry_result_t calc;
    int gap;
    gap = (calm || $urandom_range(0, 99) < 50) ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_data_offset <= off;
    in_sample_len  <= len;
    in_rate        <= rate;
    in_sample_id   <= id;
    do @(posedge clk); while (!in_ready);
    table_update(op, off, len, rate, id, calc);
    pending_results.push_back(typed ? want : calc);
    items_sent++;
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic stim_row_t make_row(logic [OP_W-1:0] op, logic [DATA_W-1:0] off,
                                         logic [LEN_W-1:0] len, logic [RATE_W-1:0] rate,
                                         logic [ID_W-1:0] id, logic typed,
                                         entry_result_t want);
    stim_row_t s;
    s.op = op; s.off = off; s.len = len; s.rate = rate; s.id = id;
    s.typed = typed; s.want = want;
    return s;
  endfunction

  initial begin : stimulus
    int i, roll, pick, fr, id_top;
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] off;
    logic [LEN_W-1:0]  len;
    logic [RATE_W-1:0] rate;
    logic [ID_W-1:0]   id;
    stim_row_t         row;
    int                n_directed;

    // empty table, then matches around the frame edge
    directed_rows.push_back(make_row(OP_FIND_ID, 24'd0, 24'd0, 16'd0, 8'd0, 1'b1,
                                     '{ST_NOT_FOUND, 8'd0, 24'd0, 24'd0, 16'd0}));
    directed_rows.push_back(make_row(OP_FIND_OFF, 24'd0, '1, '1, '1, 1'b1,
                                     '{ST_NOT_FOUND, 8'd0, 24'd0, 24'd0, 16'd0}));
    directed_rows.push_back(make_row(OP_ADD_SAMPLE, 24'd1000, 24'd50, 16'd0, 8'd0, 1'b1,
                                     '{ST_ADDED, 8'd0, 24'd1000, 24'd50, 16'd0}));
    directed_rows.push_back(make_row(OP_ADD_SAMPLE, 24'd1065, 24'd80, 16'd8000, 8'd0, 1'b0, '0));
    directed_rows.push_back(make_row(OP_ADD_SAMPLE, 24'd1134, 24'd30, 16'd0, 8'd0, 1'b0, '0));
    directed_rows.push_back(make_row(OP_ADD_SAMPLE, 24'd1132, 24'd100, 16'd123, 8'd0, 1'b0, '0));
    directed_rows.push_back(make_row(OP_ADD_SAMPLE, 24'd1000, 24'd10, 16'd0, 8'd0, 1'b0, '0));
    // low rates give a zero frame
    directed_rows.push_back(make_row(OP_ADD_SAMPLE, 24'd5000, 24'd1, 16'd59, 8'd0, 1'b0, '0));
    directed_rows.push_back(make_row(OP_ADD_SAMPLE, 24'd5000, 24'd9, 16'd0, 8'd0, 1'b0, '0));
    // bank length saturation
    directed_rows.push_back(make_row(OP_ADD_BLOCK, 24'h5a5a5a, '1, 16'hffff, 8'hff, 1'b1,
                                     '{ST_ADDED, 8'd4, 24'd0, 24'hffffff, 16'd0}));
    directed_rows.push_back(make_row(OP_ADD_BLOCK, 24'd0, 24'd5, 16'd0, 8'd0, 1'b1,
                                     '{ST_ADDED, 8'd5, 24'hffffff, 24'd5, 16'd0}));
    directed_rows.push_back(make_row(OP_ADD_BLOCK, '1, 24'd0, 16'd1, 8'd1, 1'b1,
                                     '{ST_ADDED, 8'd6, 24'hffffff, 24'd0, 16'd0}));
    directed_rows.push_back(make_row(OP_FIND_OFF, '1, 24'd0, 16'd0, 8'd0, 1'b0, '0));
    // ids in and out of range
    directed_rows.push_back(make_row(OP_FIND_ID, 24'd0, 24'd0, 16'd0, 8'd6, 1'b0, '0));
    directed_rows.push_back(make_row(OP_FIND_ID, '1, '1, '1, 8'd7, 1'b1,
                                     '{ST_NOT_FOUND, 8'd0, 24'd0, 24'd0, 16'd0}));
    directed_rows.push_back(make_row(OP_FIND_ID, 24'd0, 24'd0, 16'd0, 8'hff, 1'b1,
                                     '{ST_NOT_FOUND, 8'd0, 24'd0, 24'd0, 16'd0}));
    directed_rows.push_back(make_row(OP_ADD_SAMPLE, 24'hffffc0, '1, '1, 8'd0, 1'b0, '0));
    directed_rows.push_back(make_row(OP_FIND_OFF, 24'd0, 24'd0, 16'd0, 8'd0, 1'b0, '0));
    directed_rows.push_back(make_row(OP_ADD_SAMPLE, 24'd0, 24'd0, 16'd0, 8'd0, 1'b0, '0));
    directed_rows.push_back(make_row(OP_FIND_OFF, 24'd5000, 24'd0, 16'd0, 8'd0, 1'b0, '0));
    directed_rows.push_back(make_row(OP_ADD_SAMPLE, 24'h123456, 24'd7, '1, 8'hff, 1'b0, '0));
    directed_rows.push_back(make_row(OP_FIND_ID, 24'd0, 24'd0, 16'd0, 8'd0, 1'b0, '0));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    n_directed = directed_rows.size();
    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      send_item(row.op, row.off, row.len, row.rate, row.id, row.typed, row.want);
    end
    idle_input();
    wait_drained();

    for (i = 0; i < N_RANDOM; i++) begin
      // hold the sender until the table has settled before filling it
      if (i == FILL_AT) begin
        idle_input();
        wait_drained();
      end
      calm = (i >= 150 && i < 230);
      roll = $urandom_range(0, 99);
      if (i >= FILL_AT && tab_count < TABLE_DEPTH)
        op = (roll < 80) ? OP_ADD_BLOCK : (roll < 88) ? OP_ADD_SAMPLE :
             (roll < 94) ? OP_FIND_OFF : OP_FIND_ID;
      else
        op = (roll < 35) ? OP_ADD_SAMPLE : (roll < 45) ? OP_ADD_BLOCK :
             (roll < 75) ? OP_FIND_OFF : OP_FIND_ID;

      off = DATA_W'($urandom);
      if (tab_count > 0 && $urandom_range(0, 99) < 75) begin
        pick = $urandom_range(0, tab_count - 1);
        fr = frame_bytes(tab_rate[pick]);
        off = tab_off[pick] + DATA_W'($urandom_range(0, 2 * fr + 2)) - DATA_W'(fr + 1);
      end

      roll = $urandom_range(0, 99);
      if (op == OP_ADD_BLOCK && roll < 90) len = LEN_W'($urandom_range(0, 4000));
      else if (roll < 40) len = LEN_W'($urandom_range(0, 255));
      else if (roll < 80) len = LEN_W'($urandom);
      else if (roll < 90) len = '1;
      else len = '0;

      roll = $urandom_range(0, 99);
      if (roll < 20) rate = '0;
      else if (roll < 35) rate = RATE_W'($urandom_range(1, FRAMES_PER_SEC - 1));
      else if (roll < 90) rate = RATE_W'($urandom);
      else rate = '1;

      id_top = (tab_count > 255) ? 255 : tab_count;
      if (tab_count > 0 && $urandom_range(0, 99) < 70) id = ID_W'($urandom_range(0, id_top));
      else id = ID_W'($urandom_range(0, 255));

      send_item(op, off, len, rate, id, 1'b0, '0);
    end
    calm = 1'b0;

    idle_input();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered, count", longint'(pending_results.size()),
                      longint'(0));

    $display("ran %0d beats (%0d directed), checked %0d results, table held %0d entries",
             items_sent, n_directed, results_seen, tab_count);
    $display("statuses: added %0d confirmed %0d lengthened %0d matched %0d none %0d full %0d",
             status_hist[ST_ADDED], status_hist[ST_CONFIRMED], status_hist[ST_LENGTHENED],
             status_hist[ST_MATCHED], status_hist[ST_NOT_FOUND], status_hist[ST_FULL]);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
